/* sv/cfp_pkg.sv */
// cfp_pkg: shared types, constants and turn tables of the cube facelet permuter.
// Used by cfp_move_net and cube_facelet_permuter_unit. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cfp_pkg;

   localparam int NUM_FACES       = 6;
   localparam int FACE_SIZE       = 9;
   localparam int NUM_STICKERS    = NUM_FACES * FACE_SIZE;
   localparam int NUM_MOVES       = 18;
   localparam int CYCLES_PER_TURN = 5;
   localparam int COLOUR_W        = 3;
   localparam int FACE_W          = FACE_SIZE * COLOUR_W;
   localparam int CMD_W           = 2;
   localparam int MOVE_W          = 5;
   localparam int SEL_W           = 3;
   localparam int POS_W           = 6;

   typedef logic [COLOUR_W-1:0] colour_type;
   typedef logic [NUM_STICKERS-1:0][COLOUR_W-1:0] cube_type;
   typedef logic [FACE_W-1:0] face_word_type;
   typedef logic [POS_W-1:0] pos_type;

   typedef enum logic [CMD_W-1:0] {
      CMD_MOVE    = 2'd0,
      CMD_RESTORE = 2'd1,
      CMD_READ    = 2'd2,
      CMD_NOP     = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type             cmd;
      logic [MOVE_W-1:0]   move_code;
      logic [SEL_W-1:0]    face_select;
   } op_type;

   // Clockwise quarter turn of each face as five 4-cycles: p0->p1->p2->p3->p0.
   localparam pos_type TURN_CYCLES [NUM_FACES][CYCLES_PER_TURN][4] = '{
      '{ '{6'd0, 6'd2, 6'd8, 6'd6},     '{6'd1, 6'd5, 6'd7, 6'd3},
         '{6'd18, 6'd36, 6'd27, 6'd45}, '{6'd19, 6'd37, 6'd28, 6'd46},
         '{6'd20, 6'd38, 6'd29, 6'd47} },
      '{ '{6'd9, 6'd11, 6'd17, 6'd15},  '{6'd10, 6'd14, 6'd16, 6'd12},
         '{6'd24, 6'd51, 6'd33, 6'd42}, '{6'd25, 6'd52, 6'd34, 6'd43},
         '{6'd26, 6'd53, 6'd35, 6'd44} },
      '{ '{6'd18, 6'd20, 6'd26, 6'd24}, '{6'd19, 6'd23, 6'd25, 6'd21},
         '{6'd6, 6'd45, 6'd11, 6'd44},  '{6'd7, 6'd48, 6'd10, 6'd41},
         '{6'd8, 6'd51, 6'd9, 6'd38} },
      '{ '{6'd27, 6'd29, 6'd35, 6'd33}, '{6'd28, 6'd32, 6'd34, 6'd30},
         '{6'd0, 6'd42, 6'd17, 6'd47},  '{6'd1, 6'd39, 6'd16, 6'd50},
         '{6'd2, 6'd36, 6'd15, 6'd53} },
      '{ '{6'd36, 6'd38, 6'd44, 6'd42}, '{6'd37, 6'd41, 6'd43, 6'd39},
         '{6'd0, 6'd18, 6'd9, 6'd35},   '{6'd3, 6'd21, 6'd12, 6'd32},
         '{6'd6, 6'd24, 6'd15, 6'd29} },
      '{ '{6'd45, 6'd47, 6'd53, 6'd51}, '{6'd46, 6'd50, 6'd52, 6'd48},
         '{6'd8, 6'd27, 6'd17, 6'd26},  '{6'd5, 6'd30, 6'd14, 6'd23},
         '{6'd2, 6'd33, 6'd11, 6'd20} }
   };

   // Pure wiring when face is a constant.
   function automatic cube_type quarter_turn(input cube_type c, input int face);
      cube_type r;
      r = c;
      for (int k = 0; k < CYCLES_PER_TURN; k++) begin
         r[TURN_CYCLES[face][k][1]] = c[TURN_CYCLES[face][k][0]];
         r[TURN_CYCLES[face][k][2]] = c[TURN_CYCLES[face][k][1]];
         r[TURN_CYCLES[face][k][3]] = c[TURN_CYCLES[face][k][2]];
         r[TURN_CYCLES[face][k][0]] = c[TURN_CYCLES[face][k][3]];
      end
      return r;
   endfunction

   function automatic cube_type solved_cube();
      cube_type r;
      for (int f = 0; f < NUM_FACES; f++) begin
         for (int i = 0; i < FACE_SIZE; i++) begin
            r[f*FACE_SIZE + i] = colour_type'(f);
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

/* sv/cube_facelet_permuter_unit.sv */
// cube_facelet_permuter_unit: 3x3 cube facelet move engine, top level.
// Depends on cfp_pkg and cfp_move_net.
//
//   channel   ports                                         direction  handshake
//   request   start, busy, req_cmd, req_move_code,          in         start & !busy
//             req_face_select
//   response  rsp_strobe, rsp_solved, rsp_face_colours      out        rsp_strobe, one cycle
//
// One transfer per clock is accepted while busy is low; each gives exactly one
// response via the request register, then the cube state and response registers.
// The turn network is fixed wiring, so every operation takes a single pass.
// busy is high only during reset and the cycle after it.
// The receiver cannot stall: a response is on the ports for exactly one cycle.
// Reset (synchronous) returns the cube to the solved state.
`timescale 1ns / 1ps
`default_nettype none

module cube_facelet_permuter_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [cfp_pkg::CMD_W-1:0]     req_cmd,
   input  wire logic [cfp_pkg::MOVE_W-1:0]    req_move_code,
   input  wire logic [cfp_pkg::SEL_W-1:0]     req_face_select,
   output logic                               rsp_strobe,
   output logic                               rsp_solved,
   output logic [cfp_pkg::FACE_W-1:0]         rsp_face_colours
);
   import cfp_pkg::*;

   logic          busy_ff;
   logic          accept;

   // request register
   logic          op_valid_ff, op_valid_in;
   op_type        op_ff, op_in;

   // cube state
   cube_type      cube_ff, cube_in;

   // response register
   logic          rsp_strobe_ff;
   logic          rsp_solved_ff, rsp_solved_in;
   face_word_type rsp_face_colours_ff, rsp_face_colours_in;

   assign busy   = busy_ff;
   assign accept = start && !busy_ff;

   assign op_valid_in       = accept;
   assign op_in.cmd         = cmd_type'(req_cmd);
   assign op_in.move_code   = req_move_code;
   assign op_in.face_select = req_face_select;

   always_ff @(posedge clock) begin
      busy_ff <= reset;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_valid_ff <= 1'b0;
      end else begin
         op_valid_ff <= op_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
   end

   cfp_move_net u_move_net (
      .cube      (cube_ff),
      .op        (op_ff),
      .op_valid  (op_valid_ff),
      .cube_next (cube_in)
   );

   // Solved flag reflects the cube after this operation.
   always_comb begin
      rsp_solved_in = 1'b1;
      for (int f = 0; f < NUM_FACES; f++) begin
         for (int i = 1; i < FACE_SIZE; i++) begin
            if (cube_in[f*FACE_SIZE + i] != cube_in[f*FACE_SIZE]) begin
               rsp_solved_in = 1'b0;
            end
         end
      end
   end

   // Face read sees the cube as left by earlier operations (reads do not change it).
   always_comb begin
      rsp_face_colours_in = '0;
      if (op_ff.cmd == CMD_READ) begin
         for (int f = 0; f < NUM_FACES; f++) begin
            if (op_ff.face_select == SEL_W'(f)) begin
               rsp_face_colours_in = cube_ff[f*FACE_SIZE +: FACE_SIZE];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cube_ff       <= solved_cube();
         rsp_strobe_ff <= 1'b0;
      end else begin
         cube_ff       <= cube_in;
         rsp_strobe_ff <= op_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_solved_ff       <= rsp_solved_in;
      rsp_face_colours_ff <= rsp_face_colours_in;
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_solved       = rsp_solved_ff;
   assign rsp_face_colours = rsp_face_colours_ff;

   // ---------------------------------------------------------------- checks

   a_pipe_order: assert property (@(posedge clock) disable iff (reset)
      op_valid_ff |=> rsp_strobe_ff)
      else $error("response strobe missing after a queued operation");

   a_hold_idle: assert property (@(posedge clock) disable iff (reset)
      !op_valid_ff |=> $stable(cube_ff))
      else $error("cube state changed without an operation");

   a_restore_solved: assert property (@(posedge clock) disable iff (reset)
      (op_valid_ff && op_ff.cmd == CMD_RESTORE) |=> (rsp_solved_ff && rsp_strobe_ff))
      else $error("restore did not report a solved cube");

   a_read_only: assert property (@(posedge clock) disable iff (reset)
      (op_valid_ff && op_ff.cmd == CMD_READ) |=> $stable(cube_ff))
      else $error("face read modified the cube");

   a_colours_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && rsp_face_colours_ff != '0) |-> $past(op_ff.cmd) == CMD_READ)
      else $error("face colours driven on a non-read response");

endmodule

`default_nettype wire

/* sv/cfp_move_net.sv */
// cfp_move_net: next cube state for one operation (turn, restore or hold).
// Depends on cfp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cfp_move_net (
   input  wire cfp_pkg::cube_type cube,
   input  wire cfp_pkg::op_type   op,
   input  wire logic              op_valid,
   output cfp_pkg::cube_type      cube_next
);
   import cfp_pkg::*;

   cube_type turned [NUM_MOVES];
   cube_type moved;

   // Per face: q1 cw, q3 ccw, q2 half turn. Fixed wiring only.
   for (genvar f = 0; f < NUM_FACES; f++) begin : g_face
      cube_type q1, q2, q3;
      assign q1 = quarter_turn(cube, f);
      assign q2 = quarter_turn(q1, f);
      assign q3 = quarter_turn(q2, f);
      assign turned[f*3 + 0] = q1;
      assign turned[f*3 + 1] = q3;
      assign turned[f*3 + 2] = q2;
   end

   always_comb begin
      moved = cube;   // out-of-range move codes leave the cube alone
      for (int m = 0; m < NUM_MOVES; m++) begin
         if (op.move_code == MOVE_W'(m)) begin
            moved = turned[m];
         end
      end
   end

   always_comb begin
      cube_next = cube;
      if (op_valid) begin
         case (op.cmd)
            CMD_MOVE:    cube_next = moved;
            CMD_RESTORE: cube_next = solved_cube();
            default:     cube_next = cube;
         endcase
      end
   end

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
// tb: self-checking testbench for cube_facelet_permuter_unit (turns, restore, face reads).
// Depends on cfp_pkg for the command codes and field widths. Keeps its own sticker model
// and turn table, so it does not rely on the wiring in the package.
`timescale 1ns / 1ps

module tb;
   import cfp_pkg::*;

   // Face order U D F B L R; move code is face * 3 + variant.
   typedef enum int {FACE_U, FACE_D, FACE_F, FACE_B, FACE_L, FACE_R} face_id_type;
   typedef enum int {TURN_CW, TURN_CCW, TURN_HALF} turn_kind_type;

   typedef struct {
      cmd_type           cmd;
      logic [MOVE_W-1:0] move_code;
      logic [SEL_W-1:0]  face_select;
   } cube_op_type;

   typedef struct {
      logic              solved;
      logic [FACE_W-1:0] colours;
   } face_report_type;

   // Clockwise quarter turn: each ring of four sticker slots shifts one place,
   // so slot p0 moves to p1, p1 to p2, p2 to p3 and p3 back to p0.
   localparam int RING [6][5][4] = '{
      '{ '{0, 2, 8, 6},     '{1, 5, 7, 3},     '{18, 36, 27, 45},
         '{19, 37, 28, 46}, '{20, 38, 29, 47} },
      '{ '{9, 11, 17, 15},  '{10, 14, 16, 12}, '{24, 51, 33, 42},
         '{25, 52, 34, 43}, '{26, 53, 35, 44} },
      '{ '{18, 20, 26, 24}, '{19, 23, 25, 21}, '{6, 45, 11, 44},
         '{7, 48, 10, 41},  '{8, 51, 9, 38} },
      '{ '{27, 29, 35, 33}, '{28, 32, 34, 30}, '{0, 42, 17, 47},
         '{1, 39, 16, 50},  '{2, 36, 15, 53} },
      '{ '{36, 38, 44, 42}, '{37, 41, 43, 39}, '{0, 18, 9, 35},
         '{3, 21, 12, 32},  '{6, 24, 15, 29} },
      '{ '{45, 47, 53, 51}, '{46, 50, 52, 48}, '{8, 27, 17, 26},
         '{5, 30, 14, 23},  '{2, 33, 11, 20} }
   };

   localparam int STICKERS   = 54;
   localparam int STRIDE     = 9;
   localparam int OP_TARGET  = 440;      // queue fill level; the last scramble may overshoot
   localparam int CALM_FIRST = 180;      // transfers in this window never idle
   localparam int CALM_LAST  = 300;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   cmd_type             req_cmd;
   logic [MOVE_W-1:0]   req_move_code;
   logic [SEL_W-1:0]    req_face_select;
   logic                rsp_strobe;
   logic                rsp_solved;
   logic [FACE_W-1:0]   rsp_face_colours;

   // Sticker colours as the model sees them.
   logic [COLOUR_W-1:0] facelet [STICKERS];

   cube_op_type         pending_ops [$];
   face_report_type     face_reports [$];

   bit                  op_taken;
   int                  ops_issued;
   int                  ops_accepted;
   int                  errors;
   int                  n_turns, n_reads, n_restores, n_other, n_solved;

   cube_facelet_permuter_unit uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_cmd          (req_cmd),
      .req_move_code    (req_move_code),
      .req_face_select  (req_face_select),
      .rsp_strobe       (rsp_strobe),
      .rsp_solved       (rsp_solved),
      .rsp_face_colours (rsp_face_colours)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // ---------------------------------------------------------------- model

   function automatic void restore_model();
      for (int f = 0; f < NUM_FACES; f++) begin
         for (int i = 0; i < STRIDE; i++) begin
            facelet[f*STRIDE + i] = COLOUR_W'(f);
         end
      end
   endfunction

   function automatic void turn_face_cw(int face);
      logic [COLOUR_W-1:0] carry;
      for (int k = 0; k < 5; k++) begin
         carry                   = facelet[RING[face][k][3]];
         facelet[RING[face][k][3]] = facelet[RING[face][k][2]];
         facelet[RING[face][k][2]] = facelet[RING[face][k][1]];
         facelet[RING[face][k][1]] = facelet[RING[face][k][0]];
         facelet[RING[face][k][0]] = carry;
      end
   endfunction

   function automatic logic cube_is_uniform();
      for (int f = 0; f < NUM_FACES; f++) begin
         for (int i = 1; i < STRIDE; i++) begin
            if (facelet[f*STRIDE + i] != facelet[f*STRIDE]) return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   // Applies one transfer to the model and returns the response it must produce.
   function automatic face_report_type predict_cube_op(cube_op_type op);
      face_report_type rep;
      int              quarters;
      rep.colours = '0;
      case (op.cmd)
         CMD_MOVE: begin
            if (op.move_code < NUM_MOVES) begin
               case (op.move_code % 3)
                  TURN_CW:  quarters = 1;
                  TURN_CCW: quarters = 3;
                  default:  quarters = 2;
               endcase
               for (int t = 0; t < quarters; t++) turn_face_cw(op.move_code / 3);
            end
         end
         CMD_RESTORE: restore_model();
         CMD_READ: begin
            // face 6 or 7 reads back as all zero
            if (op.face_select < NUM_FACES) begin
               for (int i = 0; i < STRIDE; i++) begin
                  rep.colours[COLOUR_W*i +: COLOUR_W] = facelet[op.face_select*STRIDE + i];
               end
            end
         end
         default: ;   // unused command leaves the cube alone
      endcase
      rep.solved = cube_is_uniform();
      return rep;
   endfunction

   // -------------------------------------------------------------- stimulus

   function automatic void add_op(cmd_type cmd, int move_code, int face_select);
      cube_op_type op;
      op.cmd         = cmd;
      op.move_code   = MOVE_W'(move_code);
      op.face_select = SEL_W'(face_select);
      pending_ops.push_back(op);
   endfunction

   function automatic int turn_code(face_id_type face, turn_kind_type kind);
      return int'(face) * 3 + int'(kind);
   endfunction

   // Move that undoes the given one: cw and ccw swap, a half turn undoes itself.
   function automatic int undo_turn(int code);
      case (code % 3)
         TURN_CW:  return code - TURN_CW + TURN_CCW;
         TURN_CCW: return code - TURN_CCW + TURN_CW;
         default:  return code;
      endcase
   endfunction

   function automatic int junk_move();
      return $urandom_range((1 << MOVE_W) - 1);
   endfunction

   function automatic int junk_face();
      return $urandom_range((1 << SEL_W) - 1);
   endfunction

   // ---------------------------------------------------------------- driver
   // Changes inputs on the falling edge. A transfer stays on the ports until the
   // rising edge sees start high with busy low; then the next one is fetched,
   // or start drops for an idle cycle. While idle the request fields carry junk.
   always @(negedge clock) begin : drive
      cube_op_type next_op;
      bit          calm;
      if (!reset && (!start || op_taken)) begin
         calm = ops_issued >= CALM_FIRST && ops_issued < CALM_LAST;
         if (pending_ops.size() != 0 && (calm || $urandom_range(99) >= 23)) begin
            next_op = pending_ops.pop_front();
            ops_issued++;
            start           <= 1'b1;
            req_cmd         <= next_op.cmd;
            req_move_code   <= next_op.move_code;
            req_face_select <= next_op.face_select;
         end else begin
            start           <= 1'b0;
            req_cmd         <= cmd_type'($urandom_range(3));
            req_move_code   <= MOVE_W'(junk_move());
            req_face_select <= SEL_W'(junk_face());
         end
      end
   end

   // --------------------------------------------------------------- monitor
   // On the rising edge: a transfer seen here is run through the model and its
   // expected response queued; a strobed response is checked against the oldest
   // one waiting. Prediction comes first so even a same-cycle response would match.
   always @(posedge clock) begin : watch
      cube_op_type     seen;
      face_report_type want;
      op_taken = !reset && start && !busy;
      if (op_taken) begin
         seen.cmd         = req_cmd;
         seen.move_code   = req_move_code;
         seen.face_select = req_face_select;
         face_reports.push_back(predict_cube_op(seen));
         ops_accepted++;
         case (seen.cmd)
            CMD_MOVE:    n_turns++;
            CMD_READ:    n_reads++;
            CMD_RESTORE: n_restores++;
            default:     n_other++;
         endcase
      end
      if (!reset && rsp_strobe) begin
         if (face_reports.size() == 0) begin
            $display("%0t: response with none pending, solved %0b colours %h",
                     $time, rsp_solved, rsp_face_colours);
            errors++;
         end else begin
            want = face_reports.pop_front();
            if (want.solved) n_solved++;
            if (rsp_solved !== want.solved) begin
               $display("%0t: solved mismatch, expected %0b, got %0b",
                        $time, want.solved, rsp_solved);
               errors++;
            end
            if (rsp_face_colours !== want.colours) begin
               $display("%0t: face_colours mismatch, expected %h, got %h",
                        $time, want.colours, rsp_face_colours);
               errors++;
            end
         end
      end
   end

   // ------------------------------------------------------------- sequence

   initial begin : run
      int seq [8];
      int n;
      int pick;
      int drain;
      int n_total;

      reset           = 1'b1;
      start           = 1'b0;
      req_cmd         = CMD_MOVE;
      req_move_code   = '0;
      req_face_select = '0;
      op_taken        = 1'b0;
      ops_issued      = 0;
      ops_accepted    = 0;
      errors          = 0;
      n_turns = 0; n_reads = 0; n_restores = 0; n_other = 0; n_solved = 0;
      restore_model();

      // Directed: read the solved cube, one turn of each kind on several faces,
      // both out-of-range face reads, the unused command, out-of-range moves
      // including all ones, restore, then turn pairs that cancel.
      for (int f = 0; f < NUM_FACES; f++) add_op(CMD_READ, 0, f);
      add_op(CMD_MOVE, turn_code(FACE_U, TURN_CW), 0);
      add_op(CMD_MOVE, turn_code(FACE_D, TURN_CCW), 7);
      add_op(CMD_MOVE, turn_code(FACE_F, TURN_HALF), 0);
      add_op(CMD_MOVE, turn_code(FACE_B, TURN_CW), 0);
      add_op(CMD_MOVE, turn_code(FACE_L, TURN_CCW), 0);
      add_op(CMD_MOVE, turn_code(FACE_R, TURN_HALF), 0);
      add_op(CMD_READ, 31, 6);
      add_op(CMD_READ, 0, 7);
      add_op(CMD_NOP, 31, 7);
      add_op(CMD_MOVE, NUM_MOVES, 0);
      add_op(CMD_MOVE, 31, 0);
      add_op(CMD_READ, 0, FACE_R);
      add_op(CMD_RESTORE, 31, 7);
      add_op(CMD_MOVE, turn_code(FACE_U, TURN_CW), 0);
      add_op(CMD_MOVE, turn_code(FACE_U, TURN_CCW), 0);
      add_op(CMD_MOVE, turn_code(FACE_F, TURN_HALF), 0);
      add_op(CMD_MOVE, turn_code(FACE_F, TURN_HALF), 0);

      // Random: mostly scrambles with random content, half of them undone so
      // the solved flag comes back mid-run; the rest restores, reads and noise.
      while (pending_ops.size() < OP_TARGET) begin
         pick = $urandom_range(99);
         if (pick < 70) begin
            n = $urandom_range(1, 8);
            for (int j = 0; j < n; j++) begin
               seq[j] = $urandom_range(NUM_MOVES - 1);
               add_op(CMD_MOVE, seq[j], junk_face());
               if ($urandom_range(3) == 0)
                  add_op(CMD_READ, junk_move(), $urandom_range(NUM_FACES - 1));
            end
            if ($urandom_range(1)) begin
               for (int j = n - 1; j >= 0; j--) begin
                  add_op(CMD_MOVE, undo_turn(seq[j]), junk_face());
               end
            end
            add_op(CMD_READ, junk_move(), $urandom_range(NUM_FACES - 1));
         end else if (pick < 78) begin
            add_op(CMD_RESTORE, junk_move(), junk_face());
         end else if (pick < 90) begin
            add_op(CMD_READ, junk_move(), junk_face());
         end else if (pick < 95) begin
            add_op(CMD_NOP, junk_move(), junk_face());
         end else begin
            add_op(CMD_MOVE, $urandom_range((1 << MOVE_W) - 1, NUM_MOVES), junk_face());
         end
      end
      n_total = pending_ops.size();

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Every queued transfer has to be taken before draining.
      while (ops_accepted < n_total) @(posedge clock);
      // Responses trail through the request and response registers; allow a margin, then a few quiet cycles.
      for (drain = 0; drain < 50 && face_reports.size() != 0; drain++) @(posedge clock);
      repeat (5) @(posedge clock);
      if (face_reports.size() != 0) begin
         $display("%0t: %0d responses never arrived", $time, face_reports.size());
         errors++;
      end

      $display("Ran %0d transfers: %0d turns, %0d face reads, %0d restores, %0d unused commands",
               ops_accepted, n_turns, n_reads, n_restores, n_other);
      $display("%0d responses reported a solved cube, %0d check failures", n_solved, errors);
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Watchdog: a correct run needs well under 10 us.
   initial begin : watchdog
      #200_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
